// ===== hdl/lcdseq_pkg.sv =====
// Package: shared types, constants and the control-store program of the LCD nibble sequencer.
`timescale 1ns / 1ps
package lcdseq_pkg;

  // Default geometry of the frame store
  localparam int DEF_ROWS    = 2;
  localparam int DEF_COLUMNS = 16;

  // Field widths
  localparam int TICK_W   = 20;
  localparam int CHAR_W   = 8;
  localparam int NIB_W    = 4;
  localparam int CFG_IW   = 2;
  localparam int IN_DW    = 16;
  localparam int OUT_DW   = 48;
  localparam int STEP_W   = 5;

  // Configuration register reset values
  localparam logic [TICK_W-1:0] WIDE_RST   = TICK_W'(50000);
  localparam logic [TICK_W-1:0] NARROW_RST = TICK_W'(10);
  localparam logic [TICK_W-1:0] SETTLE_RST = TICK_W'(50000);

  // LCD command bytes
  localparam logic [CHAR_W-1:0] LCD_ROW0_ADDR = 8'h80;
  localparam logic [CHAR_W-1:0] LCD_ROW1_ADDR = 8'hC0;
  localparam logic [CHAR_W-1:0] LCD_WAKE      = 8'h30;
  localparam logic [CHAR_W-1:0] LCD_FOURBIT   = 8'h20;
  localparam logic [CHAR_W-1:0] LCD_FUNC_SET  = 8'h28;
  localparam logic [CHAR_W-1:0] LCD_ENTRY     = 8'h06;
  localparam logic [CHAR_W-1:0] LCD_DISP_ON   = 8'h0C;
  localparam logic [CHAR_W-1:0] LCD_ERASE     = 8'h01;

  // Input commands
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_REFRESH = 2'd2,
    CMD_INIT    = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_WIDE   = 2'd0,
    REG_NARROW = 2'd1,
    REG_SETTLE = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  // Byte source for a pulse
  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_ROW   = 2'd1,
    SRC_CHAR  = 2'd2
  } src_t;

  // One control word: every step emits one enable pulse
  typedef struct packed {
    src_t              src;
    logic              lo;        // send low nibble of the byte
    logic              wide;      // wide enable time, else narrow
    logic              rs;        // register select
    logic              last;      // final pulse of the program
    logic              cond_end;  // final pulse unless another char follows
    logic              clr;       // wipe the frame store
    logic              loop;      // jump to target when not finished
    logic [CHAR_W-1:0] value;
    logic [STEP_W-1:0] target;
  } ctl_t;

  // One pulse as it leaves the block
  typedef struct packed {
    logic [NIB_W-1:0]  nibble;
    logic              rs;
    logic [TICK_W-1:0] pulse;
    logic [TICK_W-1:0] settle;
    logic              last;
  } pulse_t;

  // Program entry points
  localparam logic [STEP_W-1:0] PC_INIT    = STEP_W'(0);
  localparam logic [STEP_W-1:0] PC_INIT_B  = STEP_W'(4);
  localparam logic [STEP_W-1:0] PC_INIT_E  = STEP_W'(15);
  localparam logic [STEP_W-1:0] PC_CLEAR   = STEP_W'(16);
  localparam logic [STEP_W-1:0] PC_REFRESH = STEP_W'(18);
  localparam logic [STEP_W-1:0] PC_CHAR    = STEP_W'(20);

  // Configuration bytes sent after the wake-up nibbles
  function automatic logic [CHAR_W-1:0] init_byte(input logic [2:0] idx);
    logic [CHAR_W-1:0] b;
    case (idx)
      3'd0:    b = LCD_FUNC_SET;
      3'd1:    b = LCD_ROW1_ADDR;
      3'd2:    b = LCD_ENTRY;
      3'd3:    b = LCD_ROW0_ADDR;
      3'd4:    b = LCD_FUNC_SET;
      3'd5:    b = LCD_DISP_ON;
      default: b = LCD_FUNC_SET;
    endcase
    return b;
  endfunction

  // Control store
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t              c;
    logic [STEP_W-1:0] rel;
    c   = '0;
    rel = step - PC_INIT_B;
    if (step >= PC_INIT_B && step <= PC_INIT_E) begin
      // init command bytes, high nibble wide then low nibble narrow
      c.src   = SRC_CONST;
      c.value = init_byte(rel[3:1]);
      c.lo    = rel[0];
      c.wide  = ~rel[0];
    end else begin
      case (step)
        STEP_W'(0), STEP_W'(1), STEP_W'(2): begin
          c.value = LCD_WAKE;
        end
        STEP_W'(3): begin
          c.value = LCD_FOURBIT;
        end
        STEP_W'(16): begin
          c.value = LCD_ERASE;
          c.wide  = 1'b1;
          c.clr   = 1'b1;
        end
        STEP_W'(17): begin
          c.value = LCD_ERASE;
          c.lo    = 1'b1;
          c.last  = 1'b1;
        end
        STEP_W'(18): begin
          c.src  = SRC_ROW;
          c.wide = 1'b1;
        end
        STEP_W'(19): begin
          c.src      = SRC_ROW;
          c.lo       = 1'b1;
          c.cond_end = 1'b1;
        end
        STEP_W'(20): begin
          c.src  = SRC_CHAR;
          c.wide = 1'b1;
          c.rs   = 1'b1;
        end
        STEP_W'(21): begin
          c.src      = SRC_CHAR;
          c.lo       = 1'b1;
          c.rs       = 1'b1;
          c.cond_end = 1'b1;
          c.loop     = 1'b1;
          c.target   = PC_CHAR;
        end
        default: begin
          c.last = 1'b1;
        end
      endcase
    end
    return c;
  endfunction

endpackage

// ===== hdl/lcdseq_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module lcdseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/lcdseq_seq.sv =====
// Step counter and control store of the nibble sequencer.
`timescale 1ns / 1ps
module lcdseq_seq
  import lcdseq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] entry,
  input  logic              adv,
  input  logic              more,
  output logic              busy,
  output ctl_t              ctl
);

  logic [STEP_W-1:0] step;
  logic              done;

  // fetch
  always_comb begin
    ctl  = ucode(step);
    done = ctl.last | (ctl.cond_end & ~more);
  end

  // step counter with conditional jump
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= PC_INIT;
    end else if (start) begin
      busy <= 1'b1;
      step <= entry;
    end else if (adv) begin
      if (done) begin
        busy <= 1'b0;
      end else if (ctl.loop) begin
        step <= ctl.target;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

endmodule

// ===== hdl/lcdseq_dp.sv =====
// Datapath: frame store, character fetch and the output word register.
`timescale 1ns / 1ps
module lcdseq_dp
  import lcdseq_pkg::*;
#(
  parameter int ROWS    = DEF_ROWS,
  parameter int COLUMNS = DEF_COLUMNS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic              wr_row,
  input  logic [3:0]        wr_col,
  input  logic [CHAR_W-1:0] wr_char,
  input  logic              start,
  input  logic              start_row,
  input  logic              adv,
  input  ctl_t              ctl,
  input  logic [TICK_W-1:0] wide_ticks,
  input  logic [TICK_W-1:0] narrow_ticks,
  input  logic [TICK_W-1:0] settle_ticks,
  input  logic              out_ready,
  output logic              out_valid,
  output pulse_t            out_word,
  output logic              more
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(COLUMNS + 1);

  logic [CW-1:0]     col;
  logic              row_q;
  logic [CHAR_W-1:0] char_q;
  logic [DEPTH-1:0]  vld;
  logic              col_ok;
  logic              rd_ok;
  logic              rd_vld;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] char_now;
  logic [CHAR_W-1:0] cur_byte;
  pulse_t            word_next;

  // addresses
  always_comb begin
    col_ok  = col < CW'(COLUMNS);
    rd_addr = col_ok ? AW'(int'(row_q) * COLUMNS + int'(col)) : '0;
    wr_addr = AW'(int'(wr_row) * COLUMNS + int'(wr_col));
  end

  lcdseq_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_char),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // per-entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv && ctl.clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // read side status follows the registered read
  always_ff @(posedge clk) begin
    rd_ok  <= col_ok;
    rd_vld <= vld[rd_addr];
  end

  always_comb begin
    char_now = rd_vld ? rd_data : '0;
    more     = rd_ok && (char_now != '0);
  end

  // column walk and current character
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row_q <= 1'b0;
    end else if (start) begin
      col   <= '0;
      row_q <= start_row;
    end else if (adv && ctl.cond_end && more) begin
      col <= col + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl.cond_end && more) begin
      char_q <= char_now;
    end
  end

  // pulse assembly
  always_comb begin
    case (ctl.src)
      SRC_CONST: cur_byte = ctl.value;
      SRC_ROW:   cur_byte = row_q ? LCD_ROW1_ADDR : LCD_ROW0_ADDR;
      SRC_CHAR:  cur_byte = char_q;
      default:   cur_byte = ctl.value;
    endcase
    word_next.nibble = ctl.lo ? cur_byte[3:0] : cur_byte[7:4];
    word_next.rs     = ctl.rs;
    word_next.pulse  = ctl.wide ? wide_ticks : narrow_ticks;
    word_next.settle = settle_ticks;
    word_next.last   = ctl.last | (ctl.cond_end & ~more);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== hdl/char_lcd_nibble_sequencer_core.sv =====
// Top level of the character LCD nibble sequencer.
//
// Input stream: one command word per item (write_char, clear, refresh_row,
// init). Output stream: one word per LCD enable pulse with its nibble, the
// register-select bit on tuser, the enable high time and the settle wait;
// tlast marks the final pulse of a command's run.
// write_char stores a byte in the frame store (2x16 by default) and emits
// nothing. clear emits 2 pulses, init 18, refresh_row 2 plus 2 per
// character up to the first zero byte (at most 34).
// The command starts the step counter and the first pulse is registered in
// the output register; after that one pulse per cycle while the receiver
// is ready, and the input is held off meanwhile. The step counter of the
// control store issues one pulse per step and the frame store is read one
// character ahead through its registered port.
// One command is worked at a time; the next is taken as soon as the last
// pulse is in the output register. A receiver stall holds the output
// register and freezes the step counter.
// Reset empties the frame store (all characters read as zero), clears the
// output and loads the timing registers with 50000, 10 and 50000 ticks.
// Timing registers are written through the cfg channel, always ready.
`timescale 1ns / 1ps
module char_lcd_nibble_sequencer_core
  import lcdseq_pkg::*;
#(
  parameter int ROWS    = DEF_ROWS,
  parameter int COLUMNS = DEF_COLUMNS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // command[1:0], row[2], column[6:3], char_code[14:7]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // nibble[3:0], pulse_ticks[23:4], wait_ticks[43:24]
  output logic              m_axis_tuser,   // reg_select
  output logic              m_axis_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [TICK_W-1:0] cfg_data
);

  logic [TICK_W-1:0] wide_ticks;
  logic [TICK_W-1:0] narrow_ticks;
  logic [TICK_W-1:0] settle_ticks;
  cmd_t              cmd;
  logic              in_row;
  logic [3:0]        in_col;
  logic [CHAR_W-1:0] in_char;
  logic              in_acc;
  logic              wr_en;
  logic              start;
  logic [STEP_W-1:0] entry;
  logic              busy;
  logic              adv;
  logic              more;
  ctl_t              ctl;
  pulse_t            out_word;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_ticks   <= WIDE_RST;
      narrow_ticks <= NARROW_RST;
      settle_ticks <= SETTLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDE:   wide_ticks   <= cfg_data;
        REG_NARROW: narrow_ticks <= cfg_data;
        REG_SETTLE: settle_ticks <= cfg_data;
        default:    ;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd     = cmd_t'(s_axis_tdata[1:0]);
    in_row  = s_axis_tdata[2];
    in_col  = s_axis_tdata[6:3];
    in_char = s_axis_tdata[14:7];
    in_acc  = s_axis_tvalid && s_axis_tready;
    wr_en   = 1'b0;
    start   = 1'b0;
    entry   = PC_INIT;
    case (cmd)
      CMD_WRITE: begin
        wr_en = in_acc && (int'(in_row) < ROWS) && (int'(in_col) < COLUMNS);
      end
      CMD_CLEAR: begin
        start = in_acc;
        entry = PC_CLEAR;
      end
      CMD_REFRESH: begin
        start = in_acc && (int'(in_row) < ROWS);
        entry = PC_REFRESH;
      end
      CMD_INIT: begin
        start = in_acc;
        entry = PC_INIT;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = ~busy;
  assign adv           = busy && (~m_axis_tvalid || m_axis_tready);

  lcdseq_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .entry (entry),
    .adv   (adv),
    .more  (more),
    .busy  (busy),
    .ctl   (ctl)
  );

  lcdseq_dp #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_row       (in_row),
    .wr_col       (in_col),
    .wr_char      (in_char),
    .start        (start),
    .start_row    (in_row),
    .adv          (adv),
    .ctl          (ctl),
    .wide_ticks   (wide_ticks),
    .narrow_ticks (narrow_ticks),
    .settle_ticks (settle_ticks),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_word     (out_word),
    .more         (more)
  );

  // output word packing
  assign m_axis_tdata = {4'b0000, out_word.settle, out_word.pulse, out_word.nibble};
  assign m_axis_tuser = out_word.rs;
  assign m_axis_tlast = out_word.last;

endmodule

// ===== hdl/lcdseq_chk.sv =====
// Port-level checker for the LCD nibble sequencer, bound to the top level.
`timescale 1ns / 1ps
module lcdseq_chk
  import lcdseq_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [IN_DW-1:0]  s_axis_tdata,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_DW-1:0] m_axis_tdata,
  input logic              m_axis_tuser,
  input logic              m_axis_tlast,
  input logic              cfg_ready
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // no new command while a run has pulses still to come
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("command taken in the middle of a run");

  // a clear always starts a run
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == CMD_CLEAR) |=>
      !s_axis_tready)
    else $error("clear did not start a run");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid && cfg_ready)
    else $error("block not idle after reset");

endmodule

bind char_lcd_nibble_sequencer_core lcdseq_chk u_lcdseq_chk (.*);
